/* src/kalman_altitude_vario_filter_core_assert.svh */
// Assertion macros for the altitude / vario filter checker.
// No dependencies; included by the checker file.
`ifndef KALMAN_ALTITUDE_VARIO_FILTER_CORE_ASSERT_SVH
`define KALMAN_ALTITUDE_VARIO_FILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KAVF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kavf check failed");

// Consequent must hold in the cycle after the antecedent.
`define KAVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kavf check failed");

`endif

/* src/kavf_pkg.sv */
// Shared types, constants and the filter microprogram.
// No dependencies; used by kavf_alu and the top level.
package kavf_pkg;

  // Fraction bits of the internal fixed-point format.
  localparam int FRAC = 24;

  // Filter constants in Q.24.
  localparam int K_DT    = 335544;
  localparam int K_DT2   = 6711;
  localparam int K_DT2H  = 3355;
  localparam int K_DT3H  = 67;
  localparam int K_DT4Q  = 1;
  localparam int K_SMOOTH = 1677722;

  // Altitude and speed output ranges.
  localparam int ALT_LO = -256000;
  localparam int ALT_HI = 3072000;
  localparam int SPD_LO = -32768;
  localparam int SPD_HI = 32767;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MEAS  = 2'd0;
  localparam logic [1:0] CFG_ACCEL = 2'd1;
  localparam logic [1:0] CFG_BIAS  = 2'd2;

  // Shared unit operations.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Operand codes: codes below RF_DEPTH live in the scratch memory.
  localparam int RF_DEPTH = 21;
  localparam logic [5:0] R_P0   = 6'd0;
  localparam logic [5:0] R_P1   = 6'd1;
  localparam logic [5:0] R_P2   = 6'd2;
  localparam logic [5:0] R_P3   = 6'd3;
  localparam logic [5:0] R_P4   = 6'd4;
  localparam logic [5:0] R_P5   = 6'd5;
  localparam logic [5:0] R_P6   = 6'd6;
  localparam logic [5:0] R_P7   = 6'd7;
  localparam logic [5:0] R_P8   = 6'd8;
  localparam logic [5:0] R_T0   = 6'd9;
  localparam logic [5:0] R_T1   = 6'd10;
  localparam logic [5:0] R_T2   = 6'd11;
  localparam logic [5:0] R_T3   = 6'd12;
  localparam logic [5:0] R_T4   = 6'd13;
  localparam logic [5:0] R_T5   = 6'd14;
  localparam logic [5:0] R_INN  = 6'd15;
  localparam logic [5:0] R_DEN  = 6'd16;
  localparam logic [5:0] R_KZ   = 6'd17;
  localparam logic [5:0] R_KV   = 6'd18;
  localparam logic [5:0] R_KA   = 6'd19;
  localparam logic [5:0] R_X    = 6'd20;
  localparam logic [5:0] R_Z    = 6'd21;
  localparam logic [5:0] R_V    = 6'd22;
  localparam logic [5:0] R_A    = 6'd23;
  localparam logic [5:0] R_S    = 6'd24;
  localparam logic [5:0] R_ZERO = 6'd25;
  localparam logic [5:0] R_ONE  = 6'd26;
  localparam logic [5:0] R_BIG  = 6'd27;
  localparam logic [5:0] R_DT   = 6'd28;
  localparam logic [5:0] R_DT2  = 6'd29;
  localparam logic [5:0] R_DT2H = 6'd30;
  localparam logic [5:0] R_DT3H = 6'd31;
  localparam logic [5:0] R_DT4Q = 6'd32;
  localparam logic [5:0] R_KSM  = 6'd33;
  localparam logic [5:0] R_ALT  = 6'd34;
  localparam logic [5:0] R_R    = 6'd35;
  localparam logic [5:0] R_QA   = 6'd36;
  localparam logic [5:0] R_QB   = 6'd37;

  // Program entry points.
  localparam logic [6:0] INIT_START = 7'd0;
  localparam logic [6:0] FILT_START = 7'd13;

  // Request from the sequencer to the shared unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  // One microprogram step: dst = a op b.
  typedef struct packed {
    logic [5:0] dst;
    logic [1:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic       last;
  } uop_t;

  function automatic uop_t mk(input logic [5:0] d, input logic [1:0] o,
                              input logic [5:0] x, input logic [5:0] y,
                              input logic l);
    uop_t u;
    u.dst  = d;
    u.op   = o;
    u.a    = x;
    u.b    = y;
    u.last = l;
    return u;
  endfunction

  // Microprogram: initialization first, then one filter update.
  function automatic uop_t ucode(input logic [6:0] idx);
    uop_t u;
    unique case (idx)
      // Initialization from the sample.
      7'd0:  u = mk(R_Z,  OP_ADD, R_ALT,  R_ZERO, 1'b0);
      7'd1:  u = mk(R_S,  OP_ADD, R_ALT,  R_ZERO, 1'b0);
      7'd2:  u = mk(R_V,  OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd3:  u = mk(R_A,  OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd4:  u = mk(R_P0, OP_ADD, R_ONE,  R_ZERO, 1'b0);
      7'd5:  u = mk(R_P1, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd6:  u = mk(R_P2, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd7:  u = mk(R_P3, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd8:  u = mk(R_P4, OP_ADD, R_ONE,  R_ZERO, 1'b0);
      7'd9:  u = mk(R_P5, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd10: u = mk(R_P6, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd11: u = mk(R_P7, OP_ADD, R_ZERO, R_ZERO, 1'b0);
      7'd12: u = mk(R_P8, OP_ADD, R_BIG,  R_ZERO, 1'b1);
      // Smoother and state prediction.
      7'd13: u = mk(R_X,  OP_SUB, R_ALT,  R_S,    1'b0);
      7'd14: u = mk(R_X,  OP_MUL, R_X,    R_KSM,  1'b0);
      7'd15: u = mk(R_S,  OP_ADD, R_S,    R_X,    1'b0);
      7'd16: u = mk(R_X,  OP_MUL, R_A,    R_DT,   1'b0);
      7'd17: u = mk(R_V,  OP_SUB, R_V,    R_X,    1'b0);
      7'd18: u = mk(R_X,  OP_MUL, R_V,    R_DT,   1'b0);
      7'd19: u = mk(R_Z,  OP_ADD, R_Z,    R_X,    1'b0);
      // Left product F*P into the temporaries.
      7'd20: u = mk(R_X,  OP_MUL, R_DT,   R_P3,   1'b0);
      7'd21: u = mk(R_T0, OP_ADD, R_P0,   R_X,    1'b0);
      7'd22: u = mk(R_X,  OP_MUL, R_DT2H, R_P6,   1'b0);
      7'd23: u = mk(R_T0, OP_SUB, R_T0,   R_X,    1'b0);
      7'd24: u = mk(R_X,  OP_MUL, R_DT,   R_P4,   1'b0);
      7'd25: u = mk(R_T1, OP_ADD, R_P1,   R_X,    1'b0);
      7'd26: u = mk(R_X,  OP_MUL, R_DT2H, R_P7,   1'b0);
      7'd27: u = mk(R_T1, OP_SUB, R_T1,   R_X,    1'b0);
      7'd28: u = mk(R_X,  OP_MUL, R_DT,   R_P5,   1'b0);
      7'd29: u = mk(R_T2, OP_ADD, R_P2,   R_X,    1'b0);
      7'd30: u = mk(R_X,  OP_MUL, R_DT2H, R_P8,   1'b0);
      7'd31: u = mk(R_T2, OP_SUB, R_T2,   R_X,    1'b0);
      7'd32: u = mk(R_X,  OP_MUL, R_DT,   R_P6,   1'b0);
      7'd33: u = mk(R_T3, OP_SUB, R_P3,   R_X,    1'b0);
      7'd34: u = mk(R_X,  OP_MUL, R_DT,   R_P7,   1'b0);
      7'd35: u = mk(R_T4, OP_SUB, R_P4,   R_X,    1'b0);
      7'd36: u = mk(R_X,  OP_MUL, R_DT,   R_P8,   1'b0);
      7'd37: u = mk(R_T5, OP_SUB, R_P5,   R_X,    1'b0);
      // Right product with the transpose back into P.
      7'd38: u = mk(R_X,  OP_MUL, R_DT,   R_T1,   1'b0);
      7'd39: u = mk(R_P0, OP_ADD, R_T0,   R_X,    1'b0);
      7'd40: u = mk(R_X,  OP_MUL, R_DT2H, R_T2,   1'b0);
      7'd41: u = mk(R_P0, OP_SUB, R_P0,   R_X,    1'b0);
      7'd42: u = mk(R_X,  OP_MUL, R_DT,   R_T2,   1'b0);
      7'd43: u = mk(R_P1, OP_SUB, R_T1,   R_X,    1'b0);
      7'd44: u = mk(R_P2, OP_ADD, R_T2,   R_ZERO, 1'b0);
      7'd45: u = mk(R_X,  OP_MUL, R_DT,   R_T4,   1'b0);
      7'd46: u = mk(R_P3, OP_ADD, R_T3,   R_X,    1'b0);
      7'd47: u = mk(R_X,  OP_MUL, R_DT2H, R_T5,   1'b0);
      7'd48: u = mk(R_P3, OP_SUB, R_P3,   R_X,    1'b0);
      7'd49: u = mk(R_X,  OP_MUL, R_DT,   R_T5,   1'b0);
      7'd50: u = mk(R_P4, OP_SUB, R_T4,   R_X,    1'b0);
      7'd51: u = mk(R_P5, OP_ADD, R_T5,   R_ZERO, 1'b0);
      7'd52: u = mk(R_X,  OP_MUL, R_DT,   R_P7,   1'b0);
      7'd53: u = mk(R_P6, OP_ADD, R_P6,   R_X,    1'b0);
      7'd54: u = mk(R_X,  OP_MUL, R_DT2H, R_P8,   1'b0);
      7'd55: u = mk(R_P6, OP_SUB, R_P6,   R_X,    1'b0);
      7'd56: u = mk(R_X,  OP_MUL, R_DT,   R_P8,   1'b0);
      7'd57: u = mk(R_P7, OP_SUB, R_P7,   R_X,    1'b0);
      // Process noise.
      7'd58: u = mk(R_X,  OP_MUL, R_DT4Q, R_QA,   1'b0);
      7'd59: u = mk(R_P0, OP_ADD, R_P0,   R_X,    1'b0);
      7'd60: u = mk(R_X,  OP_MUL, R_DT3H, R_QA,   1'b0);
      7'd61: u = mk(R_P1, OP_ADD, R_P1,   R_X,    1'b0);
      7'd62: u = mk(R_P3, OP_ADD, R_P3,   R_X,    1'b0);
      7'd63: u = mk(R_X,  OP_MUL, R_DT2,  R_QA,   1'b0);
      7'd64: u = mk(R_P4, OP_ADD, R_P4,   R_X,    1'b0);
      7'd65: u = mk(R_P8, OP_ADD, R_P8,   R_QB,   1'b0);
      // Innovation and gains.
      7'd66: u = mk(R_INN, OP_SUB, R_ALT, R_Z,    1'b0);
      7'd67: u = mk(R_DEN, OP_ADD, R_P0,  R_R,    1'b0);
      7'd68: u = mk(R_KZ, OP_DIV, R_P0,   R_DEN,  1'b0);
      7'd69: u = mk(R_KV, OP_DIV, R_P3,   R_DEN,  1'b0);
      7'd70: u = mk(R_KA, OP_DIV, R_P6,   R_DEN,  1'b0);
      // State correction.
      7'd71: u = mk(R_X,  OP_MUL, R_KZ,   R_INN,  1'b0);
      7'd72: u = mk(R_Z,  OP_ADD, R_Z,    R_X,    1'b0);
      7'd73: u = mk(R_X,  OP_MUL, R_KV,   R_INN,  1'b0);
      7'd74: u = mk(R_V,  OP_ADD, R_V,    R_X,    1'b0);
      7'd75: u = mk(R_X,  OP_MUL, R_KA,   R_INN,  1'b0);
      7'd76: u = mk(R_A,  OP_ADD, R_A,    R_X,    1'b0);
      // Covariance correction, bottom row first so the top row stays intact.
      7'd77: u = mk(R_X,  OP_MUL, R_KA,   R_P0,   1'b0);
      7'd78: u = mk(R_P6, OP_SUB, R_P6,   R_X,    1'b0);
      7'd79: u = mk(R_X,  OP_MUL, R_KA,   R_P1,   1'b0);
      7'd80: u = mk(R_P7, OP_SUB, R_P7,   R_X,    1'b0);
      7'd81: u = mk(R_X,  OP_MUL, R_KA,   R_P2,   1'b0);
      7'd82: u = mk(R_P8, OP_SUB, R_P8,   R_X,    1'b0);
      7'd83: u = mk(R_X,  OP_MUL, R_KV,   R_P0,   1'b0);
      7'd84: u = mk(R_P3, OP_SUB, R_P3,   R_X,    1'b0);
      7'd85: u = mk(R_X,  OP_MUL, R_KV,   R_P1,   1'b0);
      7'd86: u = mk(R_P4, OP_SUB, R_P4,   R_X,    1'b0);
      7'd87: u = mk(R_X,  OP_MUL, R_KV,   R_P2,   1'b0);
      7'd88: u = mk(R_P5, OP_SUB, R_P5,   R_X,    1'b0);
      7'd89: u = mk(R_X,  OP_MUL, R_KZ,   R_P0,   1'b0);
      7'd90: u = mk(R_P0, OP_SUB, R_P0,   R_X,    1'b0);
      7'd91: u = mk(R_X,  OP_MUL, R_KZ,   R_P1,   1'b0);
      7'd92: u = mk(R_P1, OP_SUB, R_P1,   R_X,    1'b0);
      7'd93: u = mk(R_X,  OP_MUL, R_KZ,   R_P2,   1'b0);
      7'd94: u = mk(R_P2, OP_SUB, R_P2,   R_X,    1'b1);
      default: u = mk(R_X, OP_ADD, R_ZERO, R_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

/* src/kalman_altitude_vario_filter_core.sv */
// Barometric altitude filter: Kalman filter plus smoothed altitude on one shared kavf_alu.
// An initializing item runs only the initialization steps; a filter update runs
// 43 add steps, 36 multiplies and 3 divides, and the divides take the longest.
// One item at a time; a new item is taken as soon as the last result is stored.
// Reset (synchronous) clears control state and loads the register defaults.
module kalman_altitude_vario_filter_core #(
  parameter int STATE_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [22:0] alt_sample,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [22:0] alt_filtered,
  output logic signed [15:0] vert_speed,
  output logic signed [15:0] accel_bias,
  output logic signed [22:0] alt_smoothed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int W  = STATE_WIDTH;
  localparam int OW = W - 16;
  localparam int AW = $clog2(kavf_pkg::RF_DEPTH);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EX   = 3'd2;
  localparam logic [2:0] ST_WT   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Clamp a non-negative value into the state range.
  function automatic logic [W-1:0] sat64(input logic [63:0] v);
    return (v > 64'(MAXV)) ? MAXV : v[W-1:0];
  endfunction

  localparam logic [W-1:0] C_ONE  = sat64(64'(1) << kavf_pkg::FRAC);
  localparam logic [W-1:0] C_BIG  = sat64(64'(100000) << kavf_pkg::FRAC);
  localparam logic [W-1:0] C_DT   = W'(kavf_pkg::K_DT);
  localparam logic [W-1:0] C_DT2  = W'(kavf_pkg::K_DT2);
  localparam logic [W-1:0] C_DT2H = W'(kavf_pkg::K_DT2H);
  localparam logic [W-1:0] C_DT3H = W'(kavf_pkg::K_DT3H);
  localparam logic [W-1:0] C_DT4Q = W'(kavf_pkg::K_DT4Q);
  localparam logic [W-1:0] C_KSM  = W'(kavf_pkg::K_SMOOTH);
  localparam logic signed [OW-1:0] O_ALT_LO = OW'(kavf_pkg::ALT_LO);
  localparam logic signed [OW-1:0] O_ALT_HI = OW'(kavf_pkg::ALT_HI);
  localparam logic signed [OW-1:0] O_SPD_LO = OW'(kavf_pkg::SPD_LO);
  localparam logic signed [OW-1:0] O_SPD_HI = OW'(kavf_pkg::SPD_HI);

  logic [2:0]              st;
  logic [6:0]              step;
  logic                    primed;
  logic [31:0]             meas_var, accel_var, bias_var;
  logic signed [22:0]      alt_q;
  logic signed [W-1:0]     z, v, bq, sm;
  logic signed [W-1:0]     rf [0:kavf_pkg::RF_DEPTH-1];
  logic signed [W-1:0]     rd_a, rd_b;
  logic signed [W-1:0]     opa, opb;
  logic [AW-1:0]           ra, rb, wa;
  kavf_pkg::uop_t          uop;
  kavf_pkg::alu_req_t      req;
  logic                    alu_done;
  logic signed [W-1:0]     alu_res;

  // Result rounding: add one half, floor shift by 16, clamp to the field range.
  function automatic logic signed [OW-1:0] to_out(input logic signed [W-1:0] x,
                                                  input logic signed [OW-1:0] lo,
                                                  input logic signed [OW-1:0] hi);
    logic [W:0]            s;
    logic [W-1:0]          y;
    logic signed [OW-1:0]  f;
    s = {x[W-1], x} + (W+1)'(32768);
    y = (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
    f = y[W-1:16];
    if (f < lo) return lo;
    if (f > hi) return hi;
    return f;
  endfunction

  // Operand selection: scratch memory, state registers or constants.
  function automatic logic signed [W-1:0] opnd(input logic [5:0] code,
                                               input logic signed [W-1:0] memv);
    case (code)
      kavf_pkg::R_Z:    return z;
      kavf_pkg::R_V:    return v;
      kavf_pkg::R_A:    return bq;
      kavf_pkg::R_S:    return sm;
      kavf_pkg::R_ZERO: return '0;
      kavf_pkg::R_ONE:  return C_ONE;
      kavf_pkg::R_BIG:  return C_BIG;
      kavf_pkg::R_DT:   return C_DT;
      kavf_pkg::R_DT2:  return C_DT2;
      kavf_pkg::R_DT2H: return C_DT2H;
      kavf_pkg::R_DT3H: return C_DT3H;
      kavf_pkg::R_DT4Q: return C_DT4Q;
      kavf_pkg::R_KSM:  return C_KSM;
      kavf_pkg::R_ALT:  return {{(W-39){alt_q[22]}}, alt_q, 16'b0};
      kavf_pkg::R_R:    return sat64({24'b0, meas_var, 8'b0});
      kavf_pkg::R_QA:   return sat64({24'b0, accel_var, 8'b0});
      kavf_pkg::R_QB:   return sat64({24'b0, bias_var, 8'b0});
      default:          return memv;
    endcase
  endfunction

  // Decode the current step and form the unit request.
  always_comb begin
    uop       = kavf_pkg::ucode(step);
    ra        = (uop.a < 6'(kavf_pkg::RF_DEPTH)) ? uop.a[AW-1:0] : '0;
    rb        = (uop.b < 6'(kavf_pkg::RF_DEPTH)) ? uop.b[AW-1:0] : '0;
    wa        = uop.dst[AW-1:0];
    opa       = opnd(uop.a, rd_a);
    opb       = opnd(uop.b, rd_b);
    req.start = (st == ST_EX);
    req.op    = uop.op;
    in_ready  = (st == ST_IDLE);
    cfg_ready = 1'b1;
  end

  kavf_alu #(.W(W)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (opa),
    .b      (opb),
    .done   (alu_done),
    .result (alu_res)
  );

  // Scratch memory for covariance, temporaries and gains.
  always_ff @(posedge clk) begin
    if (st == ST_RD) begin
      rd_a <= rf[ra];
      rd_b <= rf[rb];
    end
    if (st == ST_WT && alu_done && uop.dst < 6'(kavf_pkg::RF_DEPTH)) begin
      rf[wa] <= alu_res;
    end
  end

  // Sequencer, state registers, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      step      <= kavf_pkg::INIT_START;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      meas_var  <= 32'd65536;
      accel_var <= 32'd65536;
      bias_var  <= 32'd66;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          kavf_pkg::CFG_MEAS:  meas_var  <= cfg_data;
          kavf_pkg::CFG_ACCEL: accel_var <= cfg_data;
          kavf_pkg::CFG_BIAS:  bias_var  <= cfg_data;
          default: ;
        endcase
      end
      // The result register reloads itself in ST_OUT, so only clear it elsewhere.
      if (out_valid && out_ready && st != ST_OUT) out_valid <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            alt_q <= alt_sample;
            if (!primed || restart) begin
              step   <= kavf_pkg::INIT_START;
              primed <= 1'b1;
            end else begin
              step <= kavf_pkg::FILT_START;
            end
            st <= ST_RD;
          end
        end
        ST_RD: st <= ST_EX;
        ST_EX: st <= ST_WT;
        ST_WT: begin
          if (alu_done) begin
            case (uop.dst)
              kavf_pkg::R_Z: z  <= alu_res;
              kavf_pkg::R_V: v  <= alu_res;
              kavf_pkg::R_A: bq <= alu_res;
              kavf_pkg::R_S: sm <= alu_res;
              default: ;
            endcase
            if (uop.last) begin
              st <= ST_OUT;
            end else begin
              step <= step + 7'd1;
              st   <= ST_RD;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            alt_filtered <= 23'(to_out(z, O_ALT_LO, O_ALT_HI));
            vert_speed   <= 16'(to_out(v, O_SPD_LO, O_SPD_HI));
            accel_bias   <= 16'(to_out(bq, O_SPD_LO, O_SPD_HI));
            alt_smoothed <= 23'(to_out(sm, O_ALT_LO, O_ALT_HI));
            out_valid    <= 1'b1;
            st           <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/kavf_alu.sv */
// Shared saturating arithmetic unit: add, subtract, multiply and divide.
// Depends on kavf_pkg for operation codes and the request struct.
module kavf_alu #(
  parameter int W = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kavf_pkg::alu_req_t      req,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  output logic                    done,
  output logic signed [W-1:0]     result
);

  localparam int QW = W + kavf_pkg::FRAC;
  localparam int CW = $clog2(QW + 1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_MULFIN = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DIVFIN = 3'd5;

  logic [2:0]          st;
  logic [1:0]          opr;
  logic                neg;
  logic signed [W-1:0] xa, xb;
  logic [W-1:0]        ma, mb;
  logic [127:0]        acc;
  logic [63:0]         prod;
  logic [1:0]          psh;
  logic                pv;
  logic [2:0]          mcnt;
  logic [W-1:0]        rem;
  logic [QW-1:0]       dvd, quo;
  logic [CW-1:0]       dcnt;

  logic [63:0]         ma64, mb64;
  logic [31:0]         pa, pb;
  logic [W:0]          r2;
  logic                qbit;
  logic [128:0]        full;
  logic [104:0]        mres;
  logic [QW:0]         q1;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Signed result from magnitude and sign, saturating when too big.
  function automatic logic [W-1:0] signed_sat(input logic n, input logic big,
                                              input logic [W-1:0] m);
    if (n) return big ? MINV : (~m + 1'b1);
    return big ? MAXV : m;
  endfunction

  function automatic logic [W-1:0] addsat(input logic signed [W-1:0] x,
                                          input logic signed [W-1:0] y,
                                          input logic sub);
    logic [W:0] s;
    s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
    if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
    return s[W-1:0];
  endfunction

  // Partial product selection and divider step.
  always_comb begin
    ma64 = 64'(ma);
    mb64 = 64'(mb);
    pa   = mcnt[0] ? ma64[63:32] : ma64[31:0];
    pb   = mcnt[1] ? mb64[63:32] : mb64[31:0];
    r2   = {rem, dvd[QW-1]};
    qbit = (r2 >= {1'b0, mb});
    full = {1'b0, acc} + (129'(1) << (kavf_pkg::FRAC - 1));
    mres = full[128:kavf_pkg::FRAC];
    q1   = {1'b0, quo} + (QW+1)'({rem, 1'b0} >= {1'b0, mb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
      pv   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (req.start) begin
            xa   <= a;
            xb   <= b;
            ma   <= mag(a);
            mb   <= mag(b);
            neg  <= a[W-1] ^ b[W-1];
            opr  <= req.op;
            acc  <= '0;
            mcnt <= '0;
            pv   <= 1'b0;
            rem  <= '0;
            quo  <= '0;
            dvd  <= {mag(a), {kavf_pkg::FRAC{1'b0}}};
            dcnt <= CW'(QW);
            unique case (req.op)
              kavf_pkg::OP_ADD, kavf_pkg::OP_SUB: st <= S_ADD;
              kavf_pkg::OP_MUL: st <= S_MUL;
              default:          st <= S_DIV;
            endcase
          end
        end
        S_ADD: begin
          result <= addsat(xa, xb, opr == kavf_pkg::OP_SUB);
          done   <= 1'b1;
          st     <= S_IDLE;
        end
        // Four 32x32 partial products, each registered before it is summed.
        S_MUL: begin
          if (mcnt <= 3'd3) begin
            prod <= {32'b0, pa} * {32'b0, pb};
            psh  <= {1'b0, mcnt[0]} + {1'b0, mcnt[1]};
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            unique case (psh)
              2'd0:    acc <= acc + {64'b0, prod};
              2'd1:    acc <= acc + {32'b0, prod, 32'b0};
              default: acc <= acc + {prod, 64'b0};
            endcase
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) st <= S_MULFIN;
        end
        S_MULFIN: begin
          result <= signed_sat(neg, mres > 105'(MAXV), mres[W-1:0]);
          done   <= 1'b1;
          st     <= S_IDLE;
        end
        // Restoring division, one quotient bit per cycle; a zero divisor gives a zero result.
        S_DIV: begin
          if (mb == '0) begin
            result <= '0;
            done   <= 1'b1;
            st     <= S_IDLE;
          end else begin
            rem  <= qbit ? W'(r2 - {1'b0, mb}) : r2[W-1:0];
            quo  <= {quo[QW-2:0], qbit};
            dvd  <= {dvd[QW-2:0], 1'b0};
            dcnt <= dcnt - 1'b1;
            if (dcnt == CW'(1)) st <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          result <= signed_sat(neg, q1 > (QW+1)'(MAXV), q1[W-1:0]);
          done   <= 1'b1;
          st     <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/kavf_checker.sv */
// Port-level checks for the altitude / vario filter core, bound to the top.
// Depends on kalman_altitude_vario_filter_core_assert.svh.
`include "kalman_altitude_vario_filter_core_assert.svh"

module kavf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // The block is busy right after taking an item.
  `KAVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // No result can appear the cycle after an item is taken.
  `KAVF_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

  // A waiting result stays offered.
  `KAVF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Configuration writes are always taken.
  `KAVF_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind kalman_altitude_vario_filter_core kavf_checker u_kavf_checker (.*);
